/* src/cftc_pkg.sv */
// shared types and constants of the client flow table counter
`default_nettype none

package cftc_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // field widths
  localparam int IP_W    = 32;
  localparam int PORT_W  = 16;
  localparam int COUNT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // result status codes
  typedef enum logic [1:0] {
    ST_REPLY        = 2'd0,
    ST_IGNORED      = 2'd1,
    ST_DISCONNECTED = 2'd2,
    ST_FULL         = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [PORT_W-1:0]  port;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

`default_nettype wire

/* src/cftc_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module cftc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/client_flow_table_counter_unit.sv */
// top level: flow table with per-flow saturating reply counter
// a header on a foreign port goes straight to the finish state; any other header starts a
// linear scan of the entry ram, one read per cycle, which ends at the slot of the key or, when
// the key is new or the table is full, at the last slot.
// throughput: one item at a time; the next header is taken the cycle after the result
// is loaded, a full output register holds the result back. reset: synchronous rst_n.
`default_nettype none

module client_flow_table_counter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write: listen port
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,
  // input header stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // src_ip[31:0], src_port[47:32], dst_port[63:48]
  input  wire logic [0:0]  in_tuser,   // is_exit[0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // reply_count[31:0]
  output logic [2:0]       out_tuser   // status[1:0], new_flow[2]
);

  import cftc_pkg::*;

  // configuration
  logic [PORT_W-1:0] listen_port_r;

  // sequencer
  fsm_t state_r, state_nxt;

  // latched key
  logic [IP_W-1:0]   key_ip_r;
  logic [PORT_W-1:0] key_port_r;
  logic              key_exit_r;
  logic              ign_r;

  // scan pipeline
  logic [IDX_W-1:0]  issue_idx_r;
  logic              issue_on_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              cmp_vld_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [COUNT_W-1:0] hit_cnt_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;

  // valid bit per entry
  logic [TABLE_DEPTH-1:0] valid_r;

  // output register
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic               out_new_r;
  logic [COUNT_W-1:0] out_count_r;

  // ram interface
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;

  // combinational control
  logic               in_fire;
  logic               out_free;
  logic               cmp_match;
  logic               cmp_last;
  logic               finish_fire;
  logic               set_valid;
  logic               clr_valid;
  status_t            res_status;
  logic               res_new;
  logic [COUNT_W-1:0] res_count;
  logic [COUNT_W-1:0] inc_count;

  cftc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (issue_idx_r),
    .rdata (ram_rdata)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == FSM_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_count_r;
  assign out_tuser  = {out_new_r, out_status_r};

  // compare stage of the scan
  assign cmp_match = cmp_vld_r && valid_r[cmp_idx_r] &&
                     (ram_rdata.ip == key_ip_r) && (ram_rdata.port == key_port_r);
  assign cmp_last  = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  assign inc_count = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_tdata[63:48] != listen_port_r) ? FSM_FINISH : FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (cmp_match || cmp_last) begin
          state_nxt = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  // outputs of the sequencer: ram access and result
  always_comb begin
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = hit_r ? hit_idx_r : free_idx_r;
    ram_wdata   = '{ip: key_ip_r, port: key_port_r, count: inc_count};
    finish_fire = 1'b0;
    set_valid   = 1'b0;
    clr_valid   = 1'b0;
    res_status  = ST_FULL;
    res_new     = 1'b0;
    res_count   = '0;
    case (state_r)
      FSM_SCAN: begin
        ram_re = issue_on_r;
      end
      FSM_FINISH: begin
        finish_fire = out_free;
        if (ign_r) begin
          res_status = ST_IGNORED;
        end else if (hit_r) begin
          if (key_exit_r) begin
            res_status = ST_DISCONNECTED;
            clr_valid  = out_free;
          end else begin
            res_status = ST_REPLY;
            res_count  = inc_count;
            ram_we     = out_free;
          end
        end else if (free_found_r) begin
          res_new = 1'b1;
          if (key_exit_r) begin
            // created and removed at once: no state change
            res_status = ST_DISCONNECTED;
          end else begin
            res_status      = ST_REPLY;
            res_count       = COUNT_W'(1);
            ram_wdata.count = COUNT_W'(1);
            ram_we          = out_free;
            set_valid       = out_free;
          end
        end else begin
          res_status = ST_FULL;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= FSM_IDLE;
      listen_port_r <= '0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      issue_on_r    <= 1'b0;
      cmp_vld_r     <= 1'b0;
      hit_r         <= 1'b0;
      free_found_r  <= 1'b0;
      ign_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration transfer
      if (cfg_valid) begin
        listen_port_r <= cfg_data;
      end

      // header transfer: start a new item
      if (in_fire) begin
        ign_r        <= (in_tdata[63:48] != listen_port_r);
        issue_on_r   <= 1'b1;
        cmp_vld_r    <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end

      // scan: issue one read per cycle, compare the previous one
      if (state_r == FSM_SCAN) begin
        cmp_vld_r <= issue_on_r;
        if (issue_idx_r == LAST_IDX) begin
          issue_on_r <= 1'b0;
        end
        if (cmp_match) begin
          hit_r <= 1'b1;
        end
        if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_r <= 1'b1;
        end
      end

      // valid bit updates
      if (set_valid) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (clr_valid) begin
        valid_r[hit_idx_r] <= 1'b0;
      end

      // output register
      if (finish_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_ip_r    <= in_tdata[31:0];
      key_port_r  <= in_tdata[47:32];
      key_exit_r  <= in_tuser[0];
      issue_idx_r <= '0;
    end else if (state_r == FSM_SCAN && issue_on_r && issue_idx_r != LAST_IDX) begin
      issue_idx_r <= issue_idx_r + 1'b1;
    end

    if (state_r == FSM_SCAN) begin
      cmp_idx_r <= issue_idx_r;
      if (cmp_match) begin
        hit_idx_r <= cmp_idx_r;
        hit_cnt_r <= ram_rdata.count;
      end
      if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
        free_idx_r <= cmp_idx_r;
      end
    end

    if (finish_fire) begin
      out_status_r <= res_status;
      out_new_r    <= res_new;
      out_count_r  <= res_count;
    end
  end

endmodule

`default_nettype wire
